// ===== src/earu_pkg.sv =====
// Package for the Euler-angle point rotation unit: payload types, CORDIC constants.
// No dependencies.
package earu_pkg;

	localparam int TrigStages = 16;
	localparam int CordicSteps = (TrigStages < 24) ? TrigStages : 24;
	localparam int TrigW = 34;
	localparam int ZW = 34;

	typedef struct packed {
		logic signed [15:0] angle_a;
		logic signed [15:0] angle_b;
		logic signed [15:0] angle_g;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               last_in_group;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               out_last;
	} out_item_t;

	// one CORDIC lane: rotation vector, residual angle, negate flag
	typedef struct packed {
		logic signed [TrigW-1:0] x;
		logic signed [TrigW-1:0] y;
		logic signed [ZW-1:0]    z;
		logic                    neg;
	} lane_t;

	typedef struct packed {
		lane_t    la;
		lane_t    lb;
		lane_t    lg;
		in_item_t item;
	} cell_t;

	localparam logic signed [TrigW-1:0] CordicGain = TrigW'(652032874);
	localparam logic signed [TrigW-1:0] TrigOne = TrigW'(64'sd1073741824);

	function automatic logic signed [ZW-1:0] atan_turns(input int i);
		case (i)
			0: return ZW'(536870912);
			1: return ZW'(316933405);
			2: return ZW'(167458907);
			3: return ZW'(85004756);
			4: return ZW'(42667331);
			5: return ZW'(21354465);
			6: return ZW'(10680094);
			7: return ZW'(5340245);
			8: return ZW'(2670163);
			9: return ZW'(1335086);
			10: return ZW'(667544);
			11: return ZW'(333772);
			12: return ZW'(166886);
			13: return ZW'(83443);
			14: return ZW'(41721);
			15: return ZW'(20860);
			16: return ZW'(10430);
			17: return ZW'(5215);
			18: return ZW'(2607);
			19: return ZW'(1303);
			20: return ZW'(651);
			21: return ZW'(325);
			22: return ZW'(162);
			default: return ZW'(81);
		endcase
	endfunction

	// angle prefold into [-quarter, quarter] turn and CORDIC start vector
	function automatic lane_t lane_init(input logic signed [15:0] ang);
		lane_t l;
		logic signed [ZW-1:0] z;
		z = ZW'(ang) <<< 16;
		l.x = CordicGain;
		l.y = '0;
		l.neg = 1'b0;
		if (z > (ZW'(64'sd1) <<< 30)) begin
			z = z - (ZW'(64'sd1) <<< 31);
			l.neg = 1'b1;
		end else if (z < -(ZW'(64'sd1) <<< 30)) begin
			z = z + (ZW'(64'sd1) <<< 31);
			l.neg = 1'b1;
		end
		l.z = z;
		return l;
	endfunction

	// one micro-rotation
	function automatic lane_t lane_step(input lane_t l, input int i);
		lane_t r;
		r = l;
		if (l.z >= 0) begin
			r.x = l.x - (l.y >>> i);
			r.y = l.y + (l.x >>> i);
			r.z = l.z - atan_turns(i);
		end else begin
			r.x = l.x + (l.y >>> i);
			r.y = l.y - (l.x >>> i);
			r.z = l.z + atan_turns(i);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_trig(input logic signed [TrigW-1:0] v,
			input logic neg);
		logic signed [TrigW-1:0] t;
		t = neg ? -v : v;
		if (t > TrigOne) return 32'sd1073741824;
		if (t < -TrigOne) return -32'sd1073741824;
		return t[31:0];
	endfunction

endpackage

// ===== src/earu_cell.sv =====
// One CORDIC cell: advances all three angle lanes by one micro-rotation.
// Depends on earu_pkg.
module earu_cell import earu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [4:0] step,
	input  logic       vld_in,
	input  cell_t      d,
	output logic       vld_out,
	output cell_t      q
);
	// advance lanes and carry the point alongside
	always_ff @(posedge clk) begin
		if (en) begin
			q.la   <= lane_step(d.la, int'(step));
			q.lb   <= lane_step(d.lb, int'(step));
			q.lg   <= lane_step(d.lg, int'(step));
			q.item <= d.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end
endmodule

// ===== src/earu_matrix.sv =====
// Matrix and product pipeline: sines/cosines to nine terms, then rotated point.
// Depends on earu_pkg.
module earu_matrix import earu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_in,
	input  cell_t     d,
	output logic      vld_out,
	output out_item_t q
);
	typedef logic signed [31:0] trig_t;

	function automatic trig_t mulq(input trig_t a, input trig_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return 32'(p >>> 30);
	endfunction

	function automatic trig_t clampt(input logic signed [33:0] v);
		if (v > 34'sd1073741824) return 32'sd1073741824;
		if (v < -34'sd1073741824) return -32'sd1073741824;
		return v[31:0];
	endfunction

	trig_t sa_s1, ca_s1, sb_s1, cb_s1, sg_s1, cg_s1;
	trig_t sa_s2, ca_s2, sb_s2, cb_s2, sg_s2, cg_s2, sbsg_s2, sbcg_s2;
	trig_t m_s3 [9];
	logic signed [31:0] px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2;
	logic signed [31:0] px_s3, py_s3, pz_s3;
	logic signed [63:0] pr_s4 [9];
	logic last_s1, last_s2, last_s3, last_s4;
	logic [4:1] vld_s;

	// register saturated sines and cosines
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= clamp_trig(d.la.y, d.la.neg);
			ca_s1 <= clamp_trig(d.la.x, d.la.neg);
			sb_s1 <= clamp_trig(d.lb.y, d.lb.neg);
			cb_s1 <= clamp_trig(d.lb.x, d.lb.neg);
			sg_s1 <= clamp_trig(d.lg.y, d.lg.neg);
			cg_s1 <= clamp_trig(d.lg.x, d.lg.neg);
			px_s1 <= d.item.pos_x;
			py_s1 <= d.item.pos_y;
			pz_s1 <= d.item.pos_z;
			last_s1 <= d.item.last_in_group;
		end
	end

	// form beta-gamma products
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s2 <= sa_s1; ca_s2 <= ca_s1; sb_s2 <= sb_s1; cb_s2 <= cb_s1;
			sg_s2 <= sg_s1; cg_s2 <= cg_s1;
			sbsg_s2 <= mulq(sb_s1, sg_s1);
			sbcg_s2 <= mulq(sb_s1, cg_s1);
			px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
			last_s2 <= last_s1;
		end
	end

	// form nine matrix terms
	always_ff @(posedge clk) begin
		if (en) begin
			m_s3[0] <= mulq(ca_s2, cb_s2);
			m_s3[1] <= mulq(sa_s2, cb_s2);
			m_s3[2] <= clampt(-34'(sb_s2));
			m_s3[3] <= clampt(34'(mulq(ca_s2, sbsg_s2)) - 34'(mulq(sa_s2, cg_s2)));
			m_s3[4] <= clampt(34'(mulq(sa_s2, sbsg_s2)) + 34'(mulq(ca_s2, cg_s2)));
			m_s3[5] <= clampt(34'(mulq(cb_s2, sg_s2)));
			m_s3[6] <= clampt(34'(mulq(ca_s2, sbcg_s2)) + 34'(mulq(sa_s2, sg_s2)));
			m_s3[7] <= clampt(34'(mulq(sa_s2, sbcg_s2)) - 34'(mulq(ca_s2, sg_s2)));
			m_s3[8] <= clampt(34'(mulq(cb_s2, cg_s2)));
			px_s3 <= px_s2; py_s3 <= py_s2; pz_s3 <= pz_s2;
			last_s3 <= last_s2;
		end
	end

	// multiply terms by coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pr_s4[3*r]   <= 64'(m_s3[3*r])   * 64'(px_s3);
				pr_s4[3*r+1] <= 64'(m_s3[3*r+1]) * 64'(py_s3);
				pr_s4[3*r+2] <= 64'(m_s3[3*r+2]) * 64'(pz_s3);
			end
			last_s4 <= last_s3;
		end
	end

	// sum, round and saturate
	function automatic logic signed [31:0] fin(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic signed [63:0] c);
		logic signed [65:0] s;
		s = (66'(a) + 66'(b) + 66'(c) + 66'sd536870912) >>> 30;
		if (s > 66'sd2147483647) return 32'sh7fffffff;
		if (s < -66'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			q.out_x <= fin(pr_s4[0], pr_s4[1], pr_s4[2]);
			q.out_y <= fin(pr_s4[3], pr_s4[4], pr_s4[5]);
			q.out_z <= fin(pr_s4[6], pr_s4[7], pr_s4[8]);
			q.out_last <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[3:1], vld_in};
			vld_out <= vld_s[4];
		end
	end
endmodule

// ===== src/euler_angle_point_rotation_unit.sv =====
// Euler-angle point rotation unit: top level with CORDIC cell row and matrix pipeline.
// Depends on earu_pkg, earu_cell, earu_matrix.
//
// One point enters per cycle while the pipeline is not stalled. The path holds 16 CORDIC cells,
// one prefold register and five matrix/product stages; the whole pipeline advances
// whenever its output register is empty or being taken, so output stalls hold it.
module euler_angle_point_rotation_unit import earu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	cell_t c [CordicSteps+1];
	logic  v [CordicSteps+1];
	logic  en;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// prefold angles on transfer in
	always_ff @(posedge clk) begin
		if (en) begin
			c[0].la <= lane_init(in_data.angle_a);
			c[0].lb <= lane_init(in_data.angle_b);
			c[0].lg <= lane_init(in_data.angle_g);
			c[0].item <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
		earu_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step(5'(i)),
			.vld_in(v[i]), .d(c[i]), .vld_out(v[i+1]), .q(c[i+1])
		);
	end

	earu_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v[CordicSteps]), .d(c[CordicSteps]),
		.vld_out(out_valid), .q(out_data)
	);

	// stalled output must hold its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	// ready follows the output register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready mismatch");
endmodule

// ===== tb/earu_rotation_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Euler-angle point rotation unit: predicts each rotated point.
// Depends on earu_pkg; watches the input and output transfers of the block.
module earu_rotation_checker import earu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending_points
);

	localparam longint QOne = 64'sd1 << 30;
	localparam longint QHalf = 64'sd1 << 29;

	out_item_t rotated_q[$];

	function automatic longint atan_step(input int i);
		longint tbl[24] = '{536870912, 316933405, 167458907, 85004756, 42667331,
			21354465, 10680094, 5340245, 2670163, 1335086, 667544, 333772,
			166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};
		return tbl[i];
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + QHalf) >>> 30;
	endfunction

	// sine and cosine of a binary angle, Q1.30, CORDIC in rotation mode
	function automatic void trig(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		int steps;
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		steps = (TrigStages < 24) ? TrigStages : 24;
		if (z > (64'sd1 << 30)) begin
			z -= 64'sd1 << 31;
			flip = 1;
		end else if (z < -(64'sd1 << 30)) begin
			z += 64'sd1 << 31;
			flip = 1;
		end
		for (int i = 0; i < steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = clip(x, -QOne, QOne);
		s = clip(y, -QOne, QOne);
	endfunction

	function automatic out_item_t rotate_point(input in_item_t it);
		longint sa, ca, sb, cb, sg, cg, sbsg, sbcg, acc, r;
		longint m[3][3];
		longint p[3];
		out_item_t o;
		trig(it.angle_a, sa, ca);
		trig(it.angle_b, sb, cb);
		trig(it.angle_g, sg, cg);
		p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
		sbsg = qmul(sb, sg);
		sbcg = qmul(sb, cg);
		m[0][0] = qmul(ca, cb);
		m[0][1] = qmul(sa, cb);
		m[0][2] = -sb;
		m[1][0] = qmul(ca, sbsg) - qmul(sa, cg);
		m[1][1] = qmul(sa, sbsg) + qmul(ca, cg);
		m[1][2] = qmul(cb, sg);
		m[2][0] = qmul(ca, sbcg) + qmul(sa, sg);
		m[2][1] = qmul(sa, sbcg) - qmul(ca, sg);
		m[2][2] = qmul(cb, cg);
		for (int d = 0; d < 3; d++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += clip(m[d][k], -QOne, QOne) * p[k];
			r = clip((acc + QHalf) >>> 30, -64'sd2147483648, 64'sd2147483647);
			if (d == 0) o.out_x = r[31:0];
			else if (d == 1) o.out_y = r[31:0];
			else o.out_z = r[31:0];
		end
		o.out_last = it.last_in_group;
		return o;
	endfunction

	assign pending_points = rotated_q.size();

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				rotated_q.push_back(rotate_point(in_data));
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected point transfer: %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = rotated_q.pop_front();
					if (want !== out_data) begin
						if (fail_count < 10)
							$display("point mismatch: expected %p got %p", want, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb_euler_angle_point_rotation_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the Euler-angle point rotation unit: stimulus and verdict.
// Depends on earu_pkg, euler_angle_point_rotation_unit and earu_rotation_checker.
module tb_euler_angle_point_rotation_unit;
	import earu_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	int        fail_count;
	int        pending_points;
	int        send_idle_pct;
	int        recv_idle_pct;
	longint    cycle_count = 0;

	euler_angle_point_rotation_unit u_top (.*);

	earu_rotation_checker u_check (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog on run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("[euler_angle_point_rotation_unit] ERROR");
			$finish;
		end
	end

	// random receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh4000 + $signed(16'($urandom_range(2)) - 16'sd1);
			3: return 16'shc000 + $signed(16'($urandom_range(2)) - 16'sd1);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2: return $signed(32'($urandom_range(32'h1ffffff))) - 32'sh1000000;
			default: return $urandom;
		endcase
	endfunction

	// present one point, hold it until transferred
	task automatic send_point(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_directed();
		in_item_t it;
		logic signed [15:0] angs[6] = '{16'sd0, 16'sh8000, 16'sh7fff, 16'sh4000,
			16'shc000, 16'sh2000};
		for (int i = 0; i < 24; i++) begin
			it.angle_a = angs[i % 6];
			it.angle_b = angs[(i / 2) % 6];
			it.angle_g = angs[(i / 4) % 6];
			it.pos_x = (i % 3 == 0) ? 32'sh7fffffff : 32'sh00010000;
			it.pos_y = (i % 3 == 1) ? 32'sh80000000 : 32'sh7fffffff;
			it.pos_z = (i % 2 == 0) ? 32'sh80000000 : 32'sh7fffffff;
			it.last_in_group = i[0];
			send_point(it);
		end
	endtask

	task automatic send_random(input int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it.angle_a = pick_angle();
			it.angle_b = pick_angle();
			it.angle_g = pick_angle();
			it.pos_x = pick_coord();
			it.pos_y = pick_coord();
			it.pos_z = pick_coord();
			it.last_in_group = 1'($urandom_range(1));
			send_point(it);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		send_idle_pct = 12;
		recv_idle_pct = 58;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_directed();
		send_random(460);
		// hold off until the pipeline drains
		@(posedge clk);
		while (pending_points != 0) @(posedge clk);
		send_idle_pct = 58;
		recv_idle_pct = 12;
		send_random(480);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(480);
		@(posedge clk);
		while (pending_points != 0) @(posedge clk);
		repeat (CordicSteps + 20) @(posedge clk);
		if (fail_count == 0)
			$display("[euler_angle_point_rotation_unit] OK");
		else
			$display("[euler_angle_point_rotation_unit] ERROR");
		$finish;
	end

endmodule
